>>> sv/spq_pkg.sv
package spq_pkg;

   // Capacity of the sorted array and the width of the internal entry count.
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);

   // Field widths of the stream beats.
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 5;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } rsp_status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_BUSY = 1'b1
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the accepted request beat
      logic exec;   // apply the held request and load the result register
   } dp_cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

   // The reported count is the entry count cut or widened to its field width.
   function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, c};
      return wide[COUNT_W-1:0];
   endfunction

endpackage

>>> sv/spq_ctrl.sv
module spq_ctrl
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          slot_free;

   // The result register is free when empty or when its beat leaves now.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Output decode: execute the held request when the result slot is free.
   always_comb begin
      cmd.exec   = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
         end
         CTL_BUSY: begin
            cmd.exec   = slot_free;
            req_tready = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.load = req_tvalid && req_tready;
   end

   // Next state: a held request stays until it is executed.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (cmd.load) begin
               state_in = CTL_BUSY;
            end
         end
         CTL_BUSY: begin
            if (cmd.exec && !cmd.load) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> sv/spq_datapath.sv
module spq_datapath
   import spq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   input  logic                       req_op,
   input  logic signed [VALUE_W-1:0]  req_value,
   output rsp_status_type             rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic [COUNT_W-1:0]         rsp_count,
   output dp_status_type              status
);

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   rsp_status_type            rsp_status_ff;
   rsp_status_type            rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic signed [VALUE_W-1:0] rsp_value_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      is_full;
   logic                      is_empty;
   logic                      do_insert;
   logic                      do_remove;
   logic [DEPTH-1:0]          ge;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_insert = cmd.exec && (op_ff == OP_INSERT) && !is_full;
   assign do_remove = cmd.exec && (op_ff == OP_REMOVE) && !is_empty;

   // Request holding register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
      end
   end

   // Every stored entry compares against the new value at once. Since the
   // array is sorted descending, the hits form a prefix of the array.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ge[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] >= value_ff);
      end
   end

   // Each entry keeps its value, takes the new value, or takes its
   // neighbor's value as the array opens a gap or closes one.
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      logic signed [VALUE_W-1:0] ins_val;
      logic signed [VALUE_W-1:0] rem_val;

      if (i == 0) begin : g_first
         assign ins_val = ge[i] ? entries_ff[i] : value_ff;
      end else begin : g_rest
         assign ins_val = ge[i]   ? entries_ff[i] :
                          ge[i-1] ? value_ff : entries_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rem_val = entries_ff[i];
      end else begin : g_inner
         assign rem_val = entries_ff[i+1];
      end

      always_ff @(posedge clock) begin
         if (do_insert) begin
            entries_ff[i] <= ins_val;
         end else if (do_remove) begin
            entries_ff[i] <= rem_val;
         end
      end
   end

   // Entry count and result fields.
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      if (op_ff == OP_INSERT) begin
         if (is_full) begin
            rsp_status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (is_empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            count_in     = count_ff - CNT_W'(1);
            rsp_value_in = entries_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= to_count(count_in);
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_count    = rsp_count_ff;
   assign status.full  = is_full;
   assign status.empty = is_empty;

endmodule

>>> sv/sorted_priority_queue_unit.sv
// A request beat is held in the request holding register, then executed into the result
// register, but not while an earlier result beat is still waiting for the receiver.
// Throughput: one item per cycle while the receiver takes each result beat; each item
// is compared with all entries in parallel and the sorted array shifts in that cycle.
// Reset clears the entry count and the handshake control; the stored entries
// are not cleared and there is no clearing pass, so items are taken at once.
module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_W-1:0]     req_tdata,   // [31:0] value
   input  logic                   req_tuser,   // [0] op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] out_value, [36:32] count
   output logic [1:0]             rsp_tuser    // [1:0] status
);

   dp_cmd_type                cmd;
   dp_status_type             dp_status;
   rsp_status_type            rsp_status;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [COUNT_W-1:0]        rsp_count;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_op     (req_tuser),
      .req_value  (req_tdata),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count),
      .status     (dp_status)
   );

   // Pack the result beat.
   assign rsp_tdata = {{(RSP_TDATA_W - VALUE_W - COUNT_W){1'b0}}, rsp_count, rsp_value};
   assign rsp_tuser = rsp_status;

   // A queue is never full and empty at once.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(dp_status.full && dp_status.empty))
      else $error("queue reports full and empty together");

   // A rejected insert reports a full queue.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_FULL) |-> (rsp_count == to_count(CNT_W'(DEPTH))))
      else $error("full status with a count below capacity");

   // A rejected remove reports an empty queue and no value.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_EMPTY) |-> (rsp_count == '0 && rsp_value == '0))
      else $error("empty status with a nonzero count or value");

   // Executing an item always presents a result beat in the next cycle.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_tvalid)
      else $error("executed item gave no result beat");

endmodule
